// ===== hdl/uqpd_pkg.sv =====
// shared types, codes and helpers for the url query pair decoder
package uqpd_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned COUNT_W       = 10;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned QUEUE_DEPTH   = 4;

   localparam logic [COUNT_W-1:0] NAME_LIMIT_RESET  = 10'd63;
   localparam logic [COUNT_W-1:0] VALUE_LIMIT_RESET = 10'd1023;

   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_LIMIT = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_AMP     = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [2:0] {
      KIND_NAME_BYTE  = 3'd0,
      KIND_NAME_END   = 3'd1,
      KIND_VALUE_BYTE = 3'd2,
      KIND_PAIR_END   = 3'd3,
      KIND_ERROR      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_MALFORMED = 2'd0,
      ERR_TRUNCATED = 2'd1,
      ERR_BAD_HEX   = 2'd2,
      ERR_TOO_LONG  = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_FIRST = 2'd1,
      ESC_SECOND = 2'd2,
      ESC_UNUSED = 2'd3
   } esc_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      err_type             code;
   } result_type;

   // one accepted byte's worth of results: one or two
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // bit 4 set when not a hex digit, else the digit value in the low bits
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] l;
      logic [4:0]        r;
      l = b | CHAR_SPACE;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b0, b[3:0]};
      end else if (l >= 8'h61 && l <= 8'h66) begin
         r = {1'b0, 4'(l[3:0] + 4'd9)};
      end else begin
         r = 5'h10;
      end
      return r;
   endfunction

endpackage

// ===== hdl/uqpd_front.sv =====
// front end: takes raw bytes, tracks pair and escape state, forms result entries
module uqpd_front
   import uqpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_in_byte,
   input  logic                   req_end_of_query,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_data,
   output logic                   push,
   output entry_type              push_entry
);

   logic [COUNT_W-1:0] name_limit_ff, name_limit_in;
   logic [COUNT_W-1:0] value_limit_ff, value_limit_in;
   logic               in_value_ff, in_value_in;
   esc_type            esc_ff, esc_in;
   logic [3:0]         high_nibble_ff, high_nibble_in;
   logic               high_bad_ff, high_bad_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               value_seen_ff, value_seen_in;
   logic               skipping_ff, skipping_in;

   logic               accept;
   logic               is_amp;
   logic               main_v;
   result_type         main_r;
   logic               tail_v;
   result_type         tail_r;
   logic               err_v;
   err_type            err_c;
   logic               put;
   logic [BYTE_W-1:0]  put_byte;
   logic [COUNT_W-1:0] limit;
   logic [4:0]         hex;
   logic               do_close;
   logic               closed_ok;

   assign accept = req_valid && !req_stall;
   assign is_amp = (req_in_byte == CHAR_AMP);
   assign hex    = hex_value(req_in_byte);
   assign limit  = in_value_ff ? value_limit_ff : name_limit_ff;

   always_comb begin
      name_limit_in  = name_limit_ff;
      value_limit_in = value_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NAME_LIMIT:  name_limit_in  = csr_data;
            CSR_VALUE_LIMIT: value_limit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_value_in    = in_value_ff;
      esc_in         = esc_ff;
      high_nibble_in = high_nibble_ff;
      high_bad_in    = high_bad_ff;
      count_in       = count_ff;
      value_seen_in  = value_seen_ff;
      skipping_in    = skipping_ff;
      main_v         = 1'b0;
      main_r         = '{KIND_NAME_BYTE, '0, ERR_MALFORMED};
      tail_v         = 1'b0;
      tail_r         = '{KIND_PAIR_END, '0, ERR_MALFORMED};
      err_v          = 1'b0;
      err_c          = ERR_MALFORMED;
      put            = 1'b0;
      put_byte       = req_in_byte;
      do_close       = 1'b0;
      closed_ok      = 1'b0;

      if (skipping_ff) begin
         if (req_end_of_query) begin
            in_value_in    = 1'b0;
            esc_in         = ESC_NONE;
            high_nibble_in = '0;
            high_bad_in    = 1'b0;
            count_in       = '0;
            value_seen_in  = 1'b0;
            skipping_in    = 1'b0;
         end
      end else begin
         if (is_amp) begin
            do_close = 1'b1;
         end else begin
            if (in_value_ff) begin
               value_seen_in = 1'b1;
            end
            if (esc_ff == ESC_FIRST) begin
               high_bad_in    = hex[4];
               high_nibble_in = hex[3:0];
               esc_in         = ESC_SECOND;
            end else if (esc_ff == ESC_SECOND) begin
               esc_in         = ESC_NONE;
               high_nibble_in = '0;
               high_bad_in    = 1'b0;
               if (high_bad_ff || hex[4]) begin
                  err_v = 1'b1;
                  err_c = ERR_BAD_HEX;
               end else begin
                  put      = 1'b1;
                  put_byte = {high_nibble_ff, hex[3:0]};
               end
            end else if (req_in_byte == CHAR_PERCENT) begin
               esc_in = ESC_FIRST;
            end else if (req_in_byte == CHAR_EQUALS && !in_value_ff) begin
               main_v      = 1'b1;
               main_r      = '{KIND_NAME_END, '0, ERR_MALFORMED};
               in_value_in = 1'b1;
               count_in    = '0;
            end else begin
               put      = 1'b1;
               put_byte = (req_in_byte == CHAR_PLUS) ? CHAR_SPACE : req_in_byte;
            end

            if (put) begin
               if (count_ff >= limit) begin
                  err_v = 1'b1;
                  err_c = ERR_TOO_LONG;
               end else begin
                  count_in = count_ff + 10'd1;
                  main_v   = 1'b1;
                  main_r   = '{(in_value_ff ? KIND_VALUE_BYTE : KIND_NAME_BYTE),
                               put_byte, ERR_MALFORMED};
               end
            end
            do_close = !err_v && req_end_of_query;
         end

         if (do_close) begin
            if (esc_in == ESC_FIRST || esc_in == ESC_SECOND) begin
               err_v = 1'b1;
               err_c = ERR_TRUNCATED;
            end else if (!in_value_in || !value_seen_in) begin
               err_v = 1'b1;
               err_c = ERR_MALFORMED;
            end else begin
               tail_v    = 1'b1;
               tail_r    = '{KIND_PAIR_END, '0, ERR_MALFORMED};
               closed_ok = 1'b1;
            end
         end

         if (err_v) begin
            tail_v      = 1'b1;
            tail_r      = '{KIND_ERROR, '0, err_c};
            skipping_in = !req_end_of_query;
         end
         if (err_v || closed_ok || req_end_of_query) begin
            in_value_in    = 1'b0;
            esc_in         = ESC_NONE;
            high_nibble_in = '0;
            high_bad_in    = 1'b0;
            count_in       = '0;
            value_seen_in  = 1'b0;
         end
      end
   end

   always_comb begin
      push = accept && (main_v || tail_v);
      if (main_v) begin
         push_entry = '{main_r, tail_r, tail_v};
      end else begin
         push_entry = '{tail_r, tail_r, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_ff  <= NAME_LIMIT_RESET;
         value_limit_ff <= VALUE_LIMIT_RESET;
         in_value_ff    <= 1'b0;
         esc_ff         <= ESC_NONE;
         high_nibble_ff <= '0;
         high_bad_ff    <= 1'b0;
         count_ff       <= '0;
         value_seen_ff  <= 1'b0;
         skipping_ff    <= 1'b0;
      end else begin
         name_limit_ff  <= name_limit_in;
         value_limit_ff <= value_limit_in;
         if (accept) begin
            in_value_ff    <= in_value_in;
            esc_ff         <= esc_in;
            high_nibble_ff <= high_nibble_in;
            high_bad_ff    <= high_bad_in;
            count_ff       <= count_in;
            value_seen_ff  <= value_seen_in;
            skipping_ff    <= skipping_in;
         end
      end
   end

endmodule

// ===== hdl/uqpd_queue.sv =====
// short register queue of result entries between front and back
module uqpd_queue
   import uqpd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status  = '{empty: (count_ff == '0), full: (count_ff == CNT_W'(DEPTH))};
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/uqpd_back.sv =====
// back end: walks each queued entry out as one or two result transactions
module uqpd_back
   import uqpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  entry_type         head,
   input  queue_status_type  status,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [BYTE_W-1:0] rsp_data,
   output logic [1:0]        rsp_error_code,
   output logic              rsp_last
);

   logic       second_ff, second_in;
   logic       accept;
   result_type cur;

   assign cur            = second_ff ? head.second : head.first;
   assign rsp_valid      = !status.empty;
   assign rsp_kind       = cur.kind;
   assign rsp_data       = cur.data;
   assign rsp_error_code = cur.code;
   assign rsp_last       = second_ff || !head.two;
   assign accept         = rsp_valid && !rsp_stall;
   assign pop            = accept && rsp_last;

   always_comb begin
      second_in = second_ff;
      if (pop) begin
         second_in = 1'b0;
      end else if (accept) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ===== hdl/url_query_pair_decoder.sv =====
// top level of the url query pair decoder
// results are registered into the four-entry queue, which absorbs bursts
// throughput: one byte per cycle while the queue is not full; results leave at one
// per cycle while rsp_stall is low; a byte with two results gives two transactions
// reset: synchronous, clears pair state and queue, limits return to 63 and 1023
module url_query_pair_decoder
   import uqpd_pkg::*;
#(
   parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_in_byte,
   input  logic                   req_end_of_query,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_kind,
   output logic [BYTE_W-1:0]      rsp_data,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_data
);

   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        head;
   queue_status_type q_status;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;

   uqpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_query (req_end_of_query),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .push             (push),
      .push_entry       (push_entry)
   );

   uqpd_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   uqpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_last)
      else $error("error transaction not marked last");

   a_pair_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAIR_END |-> rsp_last)
      else $error("pair end transaction not marked last");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NAME_BYTE && rsp_kind != KIND_VALUE_BYTE
      |-> rsp_data == '0)
      else $error("data set on a marker transaction");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == '0)
      else $error("error code set on a non-error transaction");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      push && !req_stall |=> rsp_valid)
      else $error("queued entry not offered");

endmodule

// ===== dv/tb_url_query_pair_decoder.sv =====
// self-checking testbench for the url query pair decoder with a scoreboard and random queries
module tb_url_query_pair_decoder;
   import uqpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 250000;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      err_type             code;
      logic                last;
   } token_type;

   class query_scoreboard_type;
      logic [COUNT_W-1:0] name_limit;
      logic [COUNT_W-1:0] value_limit;
      bit                 at_value;
      esc_type            esc;
      logic [3:0]         hi_digit;
      bit                 hi_invalid;
      logic [COUNT_W-1:0] run_len;
      bit                 value_started;
      bit                 discarding;
      err_type            fault;
      token_type          step_out[$];
      token_type          tokens_due[$];
      int unsigned        mismatches;

      function new();
         name_limit  = NAME_LIMIT_RESET;
         value_limit = VALUE_LIMIT_RESET;
         drop_pair();
         discarding = 0;
         mismatches = 0;
      endfunction

      function void drop_pair();
         at_value      = 0;
         esc           = ESC_NONE;
         hi_digit      = '0;
         hi_invalid    = 0;
         run_len       = '0;
         value_started = 0;
      endfunction

      function void set_limit(logic [CSR_INDEX_W-1:0] idx, logic [COUNT_W-1:0] v);
         if (idx == CSR_NAME_LIMIT) begin
            name_limit = v;
         end else begin
            value_limit = v;
         end
      endfunction

      function int pending_count();
         return tokens_due.size();
      endfunction

      function void push_token(kind_type k, logic [BYTE_W-1:0] d, err_type c);
         token_type t;
         t.kind = k;
         t.data = d;
         t.code = c;
         t.last = 1'b0;
         step_out.push_back(t);
      endfunction

      // bit 4 flags a non-hex byte
      function logic [4:0] digit_of(logic [BYTE_W-1:0] b);
         logic [BYTE_W-1:0] l;
         l = b | CHAR_SPACE;
         if (b >= "0" && b <= "9") begin
            return {1'b0, 4'(b - "0")};
         end
         if (l >= "a" && l <= "f") begin
            return {1'b0, 4'(l - "a" + 10)};
         end
         return 5'h10;
      endfunction

      function bit append_byte(logic [BYTE_W-1:0] c);
         logic [COUNT_W-1:0] lim;
         lim = at_value ? value_limit : name_limit;
         if (run_len >= lim) begin
            fault = ERR_TOO_LONG;
            return 1;
         end
         run_len = run_len + 1'b1;
         if (at_value) begin
            push_token(KIND_VALUE_BYTE, c, ERR_MALFORMED);
         end else begin
            push_token(KIND_NAME_BYTE, c, ERR_MALFORMED);
         end
         return 0;
      endfunction

      function bit end_pair();
         if (esc == ESC_FIRST || esc == ESC_SECOND) begin
            fault = ERR_TRUNCATED;
            return 1;
         end
         if (!at_value || !value_started) begin
            fault = ERR_MALFORMED;
            return 1;
         end
         push_token(KIND_PAIR_END, '0, ERR_MALFORMED);
         drop_pair();
         return 0;
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b, bit eoq);
         logic [4:0] d;
         bit         failed;
         token_type  t;
         failed = 0;
         step_out.delete();
         if (discarding) begin
            if (eoq) begin
               drop_pair();
               discarding = 0;
            end
            return;
         end
         if (b == CHAR_AMP) begin
            failed = end_pair();
         end else begin
            if (at_value) begin
               value_started = 1;
            end
            case (esc)
               ESC_FIRST: begin
                  d          = digit_of(b);
                  hi_invalid = d[4];
                  hi_digit   = d[3:0];
                  esc        = ESC_SECOND;
               end
               ESC_SECOND: begin
                  d   = digit_of(b);
                  esc = ESC_NONE;
                  if (hi_invalid || d[4]) begin
                     fault  = ERR_BAD_HEX;
                     failed = 1;
                  end else begin
                     failed = append_byte({hi_digit, d[3:0]});
                  end
                  hi_digit   = '0;
                  hi_invalid = 0;
               end
               default: begin
                  if (b == CHAR_PERCENT) begin
                     esc = ESC_FIRST;
                  end else if (b == CHAR_EQUALS && !at_value) begin
                     push_token(KIND_NAME_END, '0, ERR_MALFORMED);
                     at_value = 1;
                     run_len  = '0;
                  end else if (b == CHAR_PLUS) begin
                     failed = append_byte(CHAR_SPACE);
                  end else begin
                     failed = append_byte(b);
                  end
               end
            endcase
            if (!failed && eoq) begin
               failed = end_pair();
            end
         end
         if (failed) begin
            push_token(KIND_ERROR, '0, fault);
            drop_pair();
            discarding = !eoq;
         end else if (eoq) begin
            drop_pair();
            discarding = 0;
         end
         if (step_out.size() > 0) begin
            t      = step_out.pop_back();
            t.last = 1'b1;
            step_out.push_back(t);
         end
         foreach (step_out[i]) begin
            tokens_due.push_back(step_out[i]);
         end
      endfunction

      function void match_token(token_type got);
         token_type want;
         bit        bad;
         if (tokens_due.size() == 0) begin
            $display("%0t unexpected result: expected none, actual kind %0d data %02h",
                     $time, got.kind, got.data);
            $display("%0t    code %0d last %0b", $time, got.code, got.last);
            mismatches++;
            return;
         end
         want = tokens_due.pop_front();
         bad  = 0;
         if (got.kind !== want.kind) begin
            $display("%0t kind mismatch: expected %0d, actual %0d", $time, want.kind, got.kind);
            bad = 1;
         end
         if (got.data !== want.data) begin
            $display("%0t data mismatch: expected %02h, actual %02h", $time, want.data, got.data);
            bad = 1;
         end
         if (got.code !== want.code) begin
            $display("%0t error code mismatch: expected %0d, actual %0d",
                     $time, want.code, got.code);
            bad = 1;
         end
         if (got.last !== want.last) begin
            $display("%0t last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
            bad = 1;
         end
         if (bad) begin
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_in_byte      = '0;
   logic                   req_end_of_query = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [2:0]             rsp_kind;
   logic [BYTE_W-1:0]      rsp_data;
   logic [1:0]             rsp_error_code;
   logic                   rsp_last;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_NAME_LIMIT;
   logic [COUNT_W-1:0]     csr_data         = '0;

   query_scoreboard_type sb;
   logic [BYTE_W-1:0]  qbytes[$];
   logic [COUNT_W-1:0] name_cap       = NAME_LIMIT_RESET;
   logic [COUNT_W-1:0] value_cap      = VALUE_LIMIT_RESET;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   bit                 hold_armed     = 0;
   bit                 hold_done      = 0;
   int                 hold_left      = 0;
   int unsigned        cycles         = 0;

   url_query_pair_decoder dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1;
         hold_left = 299;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      token_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.kind = kind_type'(rsp_kind);
         got.data = rsp_data;
         got.code = err_type'(rsp_error_code);
         got.last = rsp_last;
         sb.match_token(got);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit eoq);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_query <= eoq;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_byte(b, eoq);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit eoq_last);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], eoq_last && i == s.len() - 1);
      end
   endtask

   task automatic write_limits(input logic [COUNT_W-1:0] nl, input logic [COUNT_W-1:0] vl);
      csr_valid <= 1'b1;
      csr_index <= CSR_NAME_LIMIT;
      csr_data  <= nl;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_limit(CSR_NAME_LIMIT, nl);
      @(negedge clock);
      csr_index <= CSR_VALUE_LIMIT;
      csr_data  <= vl;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_limit(CSR_VALUE_LIMIT, vl);
      @(negedge clock);
      csr_valid <= 1'b0;
      name_cap  = nl;
      value_cap = vl;
   endtask

   // bytes with no result may still be in flight once the queue is empty
   task automatic drain();
      req_valid <= 1'b0;
      do begin
         while (sb.pending_count() != 0) @(negedge clock);
         repeat (8) @(negedge clock);
      end while (sb.pending_count() != 0);
   endtask

   function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n);
      if (n < 10) begin
         return 8'h30 + n;
      end
      return BYTE_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 10);
   endfunction

   function automatic logic [BYTE_W-1:0] not_hex();
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] l;
      do begin
         c = BYTE_W'($urandom_range(0, 255));
         l = c | CHAR_SPACE;
      end while ((c >= "0" && c <= "9") || (l >= "a" && l <= "f"));
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] plain_byte(bit in_name);
      logic [BYTE_W-1:0] c;
      do c = BYTE_W'($urandom_range(0, 255));
      while (c == CHAR_AMP || c == CHAR_PERCENT || c == CHAR_PLUS ||
             (in_name && c == CHAR_EQUALS));
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return CHAR_AMP;
         1: return CHAR_EQUALS;
         2: return CHAR_PERCENT;
         3: return CHAR_PLUS;
         4: return hex_char(4'($urandom_range(0, 15)));
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_len(logic [COUNT_W-1:0] lim);
      int r;
      r = int'($urandom_range(0, 9));
      if (r == 0) begin
         return 0;
      end
      if (r <= 2 && lim <= 12) begin
         return int'($urandom_range(lim, lim + 1));
      end
      return int'($urandom_range(1, 6));
   endfunction

   function automatic void add_field(int len, bit in_name);
      int r;
      for (int i = 0; i < len; i++) begin
         r = int'($urandom_range(0, 99));
         if (r < 10) begin
            qbytes.push_back(CHAR_PLUS);
         end else if (r < 30) begin
            qbytes.push_back(CHAR_PERCENT);
            qbytes.push_back(hex_char(4'($urandom_range(0, 15))));
            qbytes.push_back(hex_char(4'($urandom_range(0, 15))));
         end else if (r < 34 && !in_name) begin
            qbytes.push_back(CHAR_EQUALS);
         end else begin
            qbytes.push_back(plain_byte(in_name));
         end
      end
   endfunction

   // mostly well-formed queries, some broken by one edit, some pure noise
   function automatic void build_query();
      int style;
      int pairs;
      int pos;
      qbytes.delete();
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 12)) qbytes.push_back(noise_byte());
      end else begin
         pairs = $urandom_range(1, 3);
         for (int p = 0; p < pairs; p++) begin
            add_field(pick_len(name_cap), 1);
            qbytes.push_back(CHAR_EQUALS);
            add_field(pick_len(value_cap), 0);
            if (p < pairs - 1 || $urandom_range(0, 6) == 0) begin
               qbytes.push_back(CHAR_AMP);
            end
         end
         if (style >= 78) begin
            pos = $urandom_range(0, qbytes.size() - 1);
            case ($urandom_range(0, 4))
               0: qbytes.insert(pos, noise_byte());
               1: if (qbytes.size() > 1) qbytes.delete(pos);
               2: qbytes.push_back(CHAR_PERCENT);
               3: begin
                  qbytes.push_back(CHAR_PERCENT);
                  qbytes.push_back(hex_char(4'($urandom_range(0, 15))));
               end
               default: begin
                  if ($urandom_range(0, 1)) begin
                     qbytes.insert(pos, hex_char(4'($urandom_range(0, 15))));
                     qbytes.insert(pos, not_hex());
                  end else begin
                     qbytes.insert(pos, not_hex());
                     qbytes.insert(pos, hex_char(4'($urandom_range(0, 15))));
                  end
                  qbytes.insert(pos, CHAR_PERCENT);
               end
            endcase
         end
      end
   endfunction

   task automatic run_random(input int target);
      int done;
      done = 0;
      while (done < target) begin
         build_query();
         foreach (qbytes[i]) begin
            send_byte(qbytes[i], i == qbytes.size() - 1);
            done++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty pair, escapes in both cases, plus, later equals, bad hex, truncation
      send_text("&x", 1);
      send_text("%4a=%7E+=&%zAx", 1);
      send_text("n=v%4", 1);
      send_text("ab", 1);
      send_text("q=", 1);
      send_byte(8'h00, 0);
      send_byte(CHAR_EQUALS, 0);
      send_byte(8'hff, 1);

      drain();
      write_limits(10'd0, 10'd7);
      run_random(150);

      drain();
      write_limits(10'd4, 10'd0);
      send_idle_pct = 48;
      run_random(150);

      drain();
      write_limits(10'd2, 10'd3);
      send_idle_pct  = 0;
      recv_stall_pct = 48;
      hold_armed     = 1;
      run_random(150);

      drain();
      write_limits(10'd1023, 10'd1023);
      send_idle_pct  = 6;
      recv_stall_pct = 6;
      run_random(150);

      // a value one byte past the widest limit
      send_text("k=", 0);
      for (int i = 0; i < 1024; i++) begin
         send_byte(plain_byte(0), i == 1023);
      end

      drain();
      if (sb.mismatches == 0 && sb.pending_count() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/uqpd_pkg.sv
hdl/uqpd_front.sv
hdl/uqpd_queue.sv
hdl/uqpd_back.sv
hdl/url_query_pair_decoder.sv
dv/tb_url_query_pair_decoder.sv
